// File: rtl/bf5_pkg.sv
// Package for the 5x5 bilateral filter: op codes, widths and the controller command types.
// Used by every module of the filter; depends on nothing.
package bf5_pkg;

  localparam int MaxWidthDefault = 4096;
  localparam int PosW  = 12;
  localparam int WgtW  = 16;
  localparam int TapW  = 32;
  localparam int WSumW = 37;
  localparam int VSumW = 45;
  localparam int NumTaps = 25;

  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_SPATIAL = 2'd1;
  localparam logic [1:0] OP_RANGE   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;  // unused op, ignored

  // controller to datapath
  typedef struct packed {
    logic       load;      // take an input item
    logic       shift_dup; // shift the last column in again
    logic       acc_clear; // start a new pixel
    logic       acc_step;  // accumulate tap tap_idx
    logic [4:0] tap_idx;
    logic       div_start;
    logic       div_step;
    logic       res_load;  // latch result into the output register
  } bf5_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pixel;
    logic emit_now;    // a result is due after the load
    logic row_last;    // item closes the row
    logic pend_valid;  // position after flush shift is at least 0
    logic div_zero;    // weight sum is zero
  } bf5_sts_t;

endpackage

// File: rtl/bilateral_filter_5x5_range_lut.sv
// Top level of the 5x5 bilateral filter with range weight table.
// Depends on bf5_pkg, bf5_ctrl and bf5_datapath.
//
//  channel | direction | tdata                                  | tuser | tlast
//  in_     | input     | pixel_row0..4, table_index, weight_val | op    | last_in_row
//          |           | (first_in_row travels in tuser[2])     |       |
//  out_    | output    | filtered_pixel, column_position        | row_end | last
//
// Weight items, and columns that yield no result and close no row, are done in the accept
// cycle. Each result runs through the accept or flush-shift cycle, 25 taps one a cycle, the
// drain of the 2-stage pipe, 9 bit-serial divider steps and one output load, which raises
// out_tvalid. A row-end column runs up to three results, and a flush shift that yields
// nothing only shifts the window.
// Synchronous active-low reset clears the window and counters; the weight tables
// are not cleared. Input is taken only while idle; a waiting result holds back the
// next result load and the flush shifts, not the input.
module bilateral_filter_5x5_range_lut #(
  parameter int MAX_WIDTH = bf5_pkg::MaxWidthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // pixel_row0..4 [39:0], table_index [47:40], weight_value [63:48]
  input  logic [2:0]  in_tuser,  // op [1:0], first_in_row [2]
  input  logic        in_tlast,  // last_in_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // filtered_pixel [7:0], column_position [19:8], zero [23:20]
  output logic        out_tuser, // row_end
  output logic        out_tlast  // last
);

  bf5_pkg::bf5_cmd_t cmd;
  bf5_pkg::bf5_sts_t sts;
  logic res_is_last, res_row_end, rre, rl;
  logic [7:0] rp;
  logic [bf5_pkg::PosW-1:0] rpos;

  bf5_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts, .res_is_last, .res_row_end
  );

  bf5_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .op(in_tuser[1:0]), .col_in(in_tdata[39:0]), .first_in_row(in_tuser[2]),
    .last_in_row(in_tlast), .table_index(in_tdata[47:40]),
    .weight_value(in_tdata[63:48]), .res_is_last, .res_row_end,
    .res_pixel(rp), .res_pos(rpos), .res_row_end_o(rre), .res_last(rl)
  );

  assign out_tdata = {4'd0, rpos, rp};
  assign out_tuser = rre;
  assign out_tlast = rl;

endmodule

// File: rtl/bf5_datapath.sv
// Datapath of the 5x5 bilateral filter: window, weight tables, accumulator and divider.
// Depends on bf5_pkg.
module bf5_datapath #(
  parameter int MAX_WIDTH = bf5_pkg::MaxWidthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bf5_pkg::bf5_cmd_t cmd,
  output bf5_pkg::bf5_sts_t sts,
  input  logic [1:0]        op,
  input  logic [39:0]       col_in,
  input  logic              first_in_row,
  input  logic              last_in_row,
  input  logic [7:0]        table_index,
  input  logic [15:0]       weight_value,
  input  logic              res_is_last,
  input  logic              res_row_end,
  output logic [7:0]        res_pixel,
  output logic [bf5_pkg::PosW-1:0] res_pos,
  output logic              res_row_end_o,
  output logic              res_last
);

  localparam int CntW = $clog2(MAX_WIDTH + 3);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_WIDTH + 2);
  localparam logic [CntW-1:0] PosMax = CntW'(MAX_WIDTH - 1);

  logic [7:0]  win_r [5][5];
  logic [39:0] last_col_r;
  logic [CntW-1:0] seen_r, seen_nxt, pos_r, pos_nxt;
  logic [15:0] spat_mem [25];
  logic [15:0] rng_mem [256];
  logic [15:0] sw_r, rw_r;
  logic [7:0]  tv_r;
  logic        tap_vld_r;
  logic [bf5_pkg::TapW-1:0] prod_r;
  logic [7:0]  pv_r;
  logic        prod_vld_r;
  logic [bf5_pkg::WSumW-1:0] wsum_r;
  logic [bf5_pkg::VSumW-1:0] vsum_r;
  logic [bf5_pkg::VSumW+1:0] rem_r, den_r;
  logic [8:0]  quo_r;
  logic [3:0]  dcnt_r;
  logic [7:0]  res_pixel_r;
  logic [bf5_pkg::PosW-1:0] res_pos_r;
  logic        res_row_end_r, res_last_r;
  logic [2:0]  tr, tc;
  logic [4:0]  tbase;
  logic [7:0]  tap_pix, ctr, dif;
  logic [bf5_pkg::VSumW+1:0] trial;

  // tap index to window row and column, row-major
  always_comb begin
    if (cmd.tap_idx >= 5'd20) begin
      tr = 3'd4;
      tbase = 5'd20;
    end else if (cmd.tap_idx >= 5'd15) begin
      tr = 3'd3;
      tbase = 5'd15;
    end else if (cmd.tap_idx >= 5'd10) begin
      tr = 3'd2;
      tbase = 5'd10;
    end else if (cmd.tap_idx >= 5'd5) begin
      tr = 3'd1;
      tbase = 5'd5;
    end else begin
      tr = 3'd0;
      tbase = 5'd0;
    end
    tc = 3'(cmd.tap_idx - tbase);
  end

  assign tap_pix = win_r[tc][tr];
  assign ctr = win_r[2][2];
  assign dif = (tap_pix > ctr) ? tap_pix - ctr : ctr - tap_pix;

  // column counter for a loaded pixel item
  always_comb begin
    seen_nxt = seen_r;
    if (first_in_row || seen_r == '0) seen_nxt = CntW'(1);
    else if (seen_r < CntMax) seen_nxt = seen_r + CntW'(1);
  end

  assign sts.is_pixel   = (op == bf5_pkg::OP_PIXEL);
  assign sts.emit_now   = (seen_nxt >= CntW'(3));
  assign sts.row_last   = last_in_row;
  assign sts.pend_valid = (pos_r >= CntW'(2));
  assign sts.div_zero   = (wsum_r == '0);

  // window, counters, tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pos_r  <= '0;
      for (int c = 0; c < 5; c++)
        for (int r = 0; r < 5; r++) win_r[c][r] <= '0;
    end else if (cmd.load) begin
      case (op)
        bf5_pkg::OP_PIXEL: begin
          last_col_r <= col_in;
          if (first_in_row || seen_r == '0) begin
            for (int c = 0; c < 5; c++)
              for (int r = 0; r < 5; r++) win_r[c][r] <= col_in[8*r +: 8];
          end else begin
            for (int c = 0; c < 4; c++)
              for (int r = 0; r < 5; r++) win_r[c][r] <= win_r[c+1][r];
            for (int r = 0; r < 5; r++) win_r[4][r] <= col_in[8*r +: 8];
          end
          // pos_r holds seen-3 offset by +3 (i.e. seen value)
          pos_r  <= seen_nxt;
          seen_r <= last_in_row ? '0 : seen_nxt;
        end
        bf5_pkg::OP_SPATIAL: if (table_index < 8'(bf5_pkg::NumTaps))
          spat_mem[5'(table_index)] <= weight_value;
        bf5_pkg::OP_RANGE: rng_mem[table_index] <= weight_value;
        default: ;
      endcase
    end else if (cmd.shift_dup) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 5; r++) win_r[c][r] <= win_r[c+1][r];
      for (int r = 0; r < 5; r++) win_r[4][r] <= last_col_r[8*r +: 8];
      pos_r <= pos_r + CntW'(1);
    end
  end

  // tap pipeline: table read, multiply, accumulate
  always_ff @(posedge clk) begin
    sw_r <= spat_mem[cmd.tap_idx];
    rw_r <= rng_mem[dif];
    tv_r <= tap_pix;
    prod_r <= sw_r * rw_r;
    pv_r <= tv_r;
    if (!rst_n) begin
      tap_vld_r <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      tap_vld_r <= cmd.acc_step;
      prod_vld_r <= tap_vld_r;
    end
    if (cmd.acc_clear) begin
      wsum_r <= '0;
      vsum_r <= '0;
    end else if (prod_vld_r) begin
      wsum_r <= wsum_r + bf5_pkg::WSumW'(prod_r);
      vsum_r <= vsum_r + bf5_pkg::VSumW'(prod_r) * bf5_pkg::VSumW'(pv_r);
    end
  end

  // restoring divider, one quotient bit per step: (2V+W)/(2W)
  assign trial = rem_r - (den_r << dcnt_r);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= {vsum_r, 1'b0} + (bf5_pkg::VSumW+2)'(wsum_r);
      den_r  <= (bf5_pkg::VSumW+2)'({wsum_r, 1'b0});
      quo_r  <= '0;
      dcnt_r <= 4'd8;
    end else if (cmd.div_step) begin
      if (rem_r >= (den_r << dcnt_r)) begin
        rem_r <= trial;
        quo_r[dcnt_r] <= 1'b1;
      end
      dcnt_r <= dcnt_r - 4'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (wsum_r == '0) res_pixel_r <= ctr;
      else res_pixel_r <= quo_r[8] ? 8'hFF : quo_r[7:0];
      res_pos_r <= bf5_pkg::PosW'((pos_r - CntW'(3) > PosMax) ? PosMax
                                                              : pos_r - CntW'(3));
      res_row_end_r <= res_row_end;
      res_last_r    <= res_is_last;
    end
  end

  assign res_pixel     = res_pixel_r;
  assign res_pos       = res_pos_r;
  assign res_row_end_o = res_row_end_r;
  assign res_last      = res_last_r;

endmodule

// File: rtl/bf5_ctrl.sv
// Controller of the 5x5 bilateral filter: sequences load, flush shifts, taps, divide and output.
// Depends on bf5_pkg.
module bf5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bf5_pkg::bf5_cmd_t cmd,
  input  bf5_pkg::bf5_sts_t sts,
  output logic              res_is_last,
  output logic              res_row_end
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TAPS  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_DIV   = 6'b001000,
    S_OUT   = 6'b010000,
    S_SHIFT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] tap_r, tap_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] flush_r, flush_nxt;   // flush shifts still to run
  logic       row_r, row_nxt;       // current column closes its row
  logic       out_vld_r, out_vld_nxt;
  logic       acc_go;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign res_is_last = (flush_r == 2'd0);
  assign res_row_end = (flush_r == 2'd0) && row_r;

  always_comb begin
    state_nxt = state_r;
    tap_nxt = tap_r;
    cnt_nxt = cnt_r;
    flush_nxt = flush_r;
    row_nxt = row_r;
    out_vld_nxt = out_vld_r && !out_tready;
    cmd = '0;
    cmd.tap_idx = tap_r;
    acc_go = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        cmd.load = 1'b1;
        if (sts.is_pixel) begin
          flush_nxt = sts.row_last ? 2'd2 : 2'd0;
          row_nxt = sts.row_last;
          if (sts.emit_now) acc_go = 1'b1;
          else if (sts.row_last) state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: if (!out_vld_r) begin
        cmd.shift_dup = 1'b1;
        flush_nxt = flush_r - 2'd1;
        if (sts.pend_valid) acc_go = 1'b1;
        else if (flush_r == 2'd1) state_nxt = S_IDLE;
      end
      S_TAPS: begin
        cmd.acc_step = 1'b1;
        tap_nxt = tap_r + 5'd1;
        if (tap_r == 5'(bf5_pkg::NumTaps - 1)) begin
          state_nxt = S_DRAIN;
          cnt_nxt = 4'd2;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 4'd8;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = S_OUT;
      end
      S_OUT: if (!out_vld_r) begin
        cmd.res_load = 1'b1;
        out_vld_nxt = 1'b1;
        state_nxt = (flush_r != 2'd0) ? S_SHIFT : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (acc_go) begin
      cmd.acc_clear = 1'b1;
      tap_nxt = '0;
      state_nxt = S_TAPS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r <= '0;
      cnt_r <= '0;
      flush_r <= '0;
      row_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r <= tap_nxt;
      cnt_r <= cnt_nxt;
      flush_r <= flush_nxt;
      row_r <= row_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: rtl/bf5_checker.sv
// Port-level checker for the 5x5 bilateral filter, bound to the top level.
// Depends on bilateral_filter_5x5_range_lut ports only.
module bf5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output payload changed while stalled");

  // row end results always close the item
  a_rowend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("row_end without last");

  // an offered input item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("input item withdrawn before it was taken");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("tdata padding not zero");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind bilateral_filter_5x5_range_lut bf5_checker u_bf5_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tuser, .out_tlast
);
